// File: hw/rtl/srtmed_pkg.sv
// types and constants shared by the sorted list median block
`default_nettype none
package srtmed_pkg;

	localparam int unsigned CMD_W       = 2;
	localparam int unsigned VAL_W       = 16;
	localparam int unsigned LCNT_W      = 7;
	localparam int unsigned HELD_W      = 7;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned IN_TDATA_W  = 24;
	localparam int unsigned OUT_TDATA_W = 72;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_LIST   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_FIN,
		S_Q_RD,
		S_Q_RES,
		S_L_RD,
		S_L_WAIT
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0]  item;
		logic [VAL_W-1:0]  median;
		logic [VAL_W-1:0]  largest;
		logic [VAL_W-1:0]  smallest;
		logic [HELD_W-1:0] held;
		status_t           status;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/srtmed_obuf.sv
// output register stage for result items
`default_nettype none
module srtmed_obuf (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire srtmed_pkg::result_t                 res,
	output logic                                     free,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// item, median, largest, smallest, held, zero pad
	output logic [srtmed_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// status
	output logic [srtmed_pkg::STATUS_W-1:0]          m_tuser,
	output logic                                     m_tlast
);

	logic                valid_q;
	srtmed_pkg::result_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, res_q.held, res_q.smallest, res_q.largest,
		res_q.median, res_q.item};
	assign m_tuser  = res_q.status;
	assign m_tlast  = res_q.last;

endmodule
`default_nettype wire

// File: hw/rtl/sorted_int_list_median.sv
// sorted store with insert, median query and listing of leading entries
//
//  channel  dir  payload                                      end of item
//  s_*      in   tuser: cmd; tdata: value, list_count         s_tvalid & s_tready
//  m_*      out  tuser: status; tdata: item, median, largest,  m_tvalid & m_tready
//                smallest, held; tlast: last
//
// one command is worked at a time through the read port and write port of the store
// insert: reads and shifts up each larger entry in turn, then writes the value
// query: four reads of the store then the result; list: each entry read, then output
// reset clears the fill count and control state; the store itself needs no clearing
// a stalled result holds the last step of a command until the output register frees
`default_nettype none
module sorted_int_list_median #(
	parameter int unsigned DEPTH      = 64,
	parameter int unsigned VALUE_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// value, list_count, zero pad
	input  wire logic [srtmed_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd
	input  wire logic [srtmed_pkg::CMD_W-1:0]        s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// item, median, largest, smallest, held, zero pad
	output logic [srtmed_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// status
	output logic [srtmed_pkg::STATUS_W-1:0]          m_tuser,
	output logic                                     m_tlast
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned VB = VALUE_BITS;

	srtmed_pkg::state_t  state_q, state_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       k_q, k_d;
	logic [CW-1:0]       count_q, count_d;
	logic [2:0]          qstep_q, qstep_d;
	logic [VB-1:0]       val_q, val_d;
	logic [VB-1:0]       small_q, small_d;
	logic [VB-1:0]       large_q, large_d;
	logic [VB-1:0]       mlo_q, mlo_d;
	logic [VB-1:0]       mhi_q, mhi_d;
	srtmed_pkg::status_t fin_status_q, fin_status_d;

	logic [VB-1:0]       mem [DEPTH];
	logic [VB-1:0]       rd_data_q;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [VB-1:0]       mem_wdata;

	logic                out_load, out_free;
	srtmed_pkg::result_t out_res;

	logic                in_acc;
	logic [AW-1:0]       mid;
	logic [VB:0]         msum;
	logic [srtmed_pkg::LCNT_W-1:0] want;

	assign s_tready = (state_q == srtmed_pkg::S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign mid    = AW'(count_q >> 1);
	assign msum   = (VB+1)'(mlo_q) + (VB+1)'(mhi_q);
	assign want   = s_tdata[srtmed_pkg::VAL_W +: srtmed_pkg::LCNT_W];

	// store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= srtmed_pkg::S_IDLE;
			count_q      <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			qstep_q      <= '0;
			fin_status_q <= srtmed_pkg::STAT_OK;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			pos_q        <= pos_d;
			idx_q        <= idx_d;
			k_q          <= k_d;
			qstep_q      <= qstep_d;
			fin_status_q <= fin_status_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q   <= val_d;
		small_q <= small_d;
		large_q <= large_d;
		mlo_q   <= mlo_d;
		mhi_q   <= mhi_d;
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		pos_d        = pos_q;
		idx_d        = idx_q;
		k_d          = k_q;
		qstep_d      = qstep_q;
		fin_status_d = fin_status_q;
		val_d        = val_q;
		small_d      = small_q;
		large_d      = large_q;
		mlo_d        = mlo_q;
		mhi_d        = mhi_q;
		mem_we       = 1'b0;
		mem_waddr    = pos_q;
		mem_wdata    = val_q;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		out_load     = 1'b0;
		out_res      = '0;
		out_res.held   = srtmed_pkg::HELD_W'(count_q);
		out_res.status = srtmed_pkg::STAT_OK;
		out_res.last   = 1'b1;

		case (state_q)
			srtmed_pkg::S_IDLE: begin
				if (in_acc) begin
					case (srtmed_pkg::cmd_t'(s_tuser))
						srtmed_pkg::CMD_INSERT: begin
							if (count_q == CW'(DEPTH)) begin
								fin_status_d = srtmed_pkg::STAT_FULL;
								state_d      = srtmed_pkg::S_FIN;
							end else begin
								pos_d   = AW'(count_q);
								val_d   = VB'(s_tdata[srtmed_pkg::VAL_W-1:0]);
								state_d = srtmed_pkg::S_INS_RD;
							end
						end
						srtmed_pkg::CMD_QUERY: begin
							if (count_q == '0) begin
								fin_status_d = srtmed_pkg::STAT_EMPTY;
								state_d      = srtmed_pkg::S_FIN;
							end else begin
								qstep_d = '0;
								state_d = srtmed_pkg::S_Q_RD;
							end
						end
						srtmed_pkg::CMD_LIST: begin
							if (count_q == '0) begin
								fin_status_d = srtmed_pkg::STAT_EMPTY;
								state_d      = srtmed_pkg::S_FIN;
							end else if (want == '0) begin
								fin_status_d = srtmed_pkg::STAT_OK;
								state_d      = srtmed_pkg::S_FIN;
							end else begin
								k_d     = (want < srtmed_pkg::LCNT_W'(count_q)) ?
									CW'(want) : count_q;
								idx_d   = '0;
								state_d = srtmed_pkg::S_L_RD;
							end
						end
						default: begin
							state_d = srtmed_pkg::S_IDLE;
						end
					endcase
				end
			end

			srtmed_pkg::S_INS_RD: begin
				if (pos_q == '0) begin
					mem_we       = 1'b1;
					mem_waddr    = '0;
					mem_wdata    = val_q;
					count_d      = count_q + CW'(1);
					fin_status_d = srtmed_pkg::STAT_OK;
					state_d      = srtmed_pkg::S_FIN;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = pos_q - AW'(1);
					state_d   = srtmed_pkg::S_INS_CMP;
				end
			end

			// rd_data_q holds the entry just below pos
			srtmed_pkg::S_INS_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				if (rd_data_q > val_q) begin
					mem_wdata = rd_data_q;
					pos_d     = pos_q - AW'(1);
					if (pos_q == AW'(1)) begin
						state_d = srtmed_pkg::S_INS_RD;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = pos_q - AW'(2);
					end
				end else begin
					mem_wdata    = val_q;
					count_d      = count_q + CW'(1);
					fin_status_d = srtmed_pkg::STAT_OK;
					state_d      = srtmed_pkg::S_FIN;
				end
			end

			srtmed_pkg::S_FIN: begin
				out_res.status = fin_status_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = srtmed_pkg::S_IDLE;
				end
			end

			// reads smallest, largest and the two middles back to back
			srtmed_pkg::S_Q_RD: begin
				qstep_d = qstep_q + 3'd1;
				case (qstep_q)
					3'd0: begin
						mem_re    = 1'b1;
						mem_raddr = '0;
					end
					3'd1: begin
						mem_re    = 1'b1;
						mem_raddr = AW'(count_q - CW'(1));
						small_d   = rd_data_q;
					end
					3'd2: begin
						mem_re    = 1'b1;
						mem_raddr = count_q[0] ? mid : mid - AW'(1);
						large_d   = rd_data_q;
					end
					3'd3: begin
						mem_re    = 1'b1;
						mem_raddr = mid;
						mlo_d     = rd_data_q;
					end
					default: begin
						mhi_d   = rd_data_q;
						state_d = srtmed_pkg::S_Q_RES;
					end
				endcase
			end

			srtmed_pkg::S_Q_RES: begin
				out_res.median   = srtmed_pkg::VAL_W'(msum[VB:1]);
				out_res.largest  = srtmed_pkg::VAL_W'(large_q);
				out_res.smallest = srtmed_pkg::VAL_W'(small_q);
				if (out_free) begin
					out_load = 1'b1;
					state_d  = srtmed_pkg::S_IDLE;
				end
			end

			// read only when the output register is sure to be free next cycle
			srtmed_pkg::S_L_RD: begin
				if (out_free) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q;
					state_d   = srtmed_pkg::S_L_WAIT;
				end
			end

			srtmed_pkg::S_L_WAIT: begin
				out_load     = 1'b1;
				out_res.item = srtmed_pkg::VAL_W'(rd_data_q);
				out_res.last = ((CW'(idx_q) + CW'(1)) == k_q);
				if (out_res.last) begin
					state_d = srtmed_pkg::S_IDLE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = srtmed_pkg::S_L_RD;
				end
			end

			default: begin
				state_d = srtmed_pkg::S_IDLE;
			end
		endcase
	end

	srtmed_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (out_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire
